### hw/rtl/tun_pkg.sv
package tun_pkg;

  // default coordinate and result widths
  localparam int COORD_BITS  = 24;
  localparam int NORMAL_BITS = 16;

  // register stages of the front end and of the squaring, ahead of the bit-by-bit magnitude search
  localparam int FRONT_STAGES  = 3;
  localparam int SQUARE_STAGES = 3;

  // command codes
  localparam logic CMD_TRIANGLE  = 1'b0;
  localparam logic CMD_NORMALIZE = 1'b1;

endpackage

### hw/rtl/triangle_unit_normal_unit.sv
// Unit face normal: each item is a triangle (command 0, normal of b-a x c-a) or a
// vector a (command 1) and gives one item of Q1.(NormalBits-1) components with a
// degenerate flag for zero length. One item enters per cycle while in_ready_o is
// high; the pipeline has three stages for edges and cross product, three for the
// exact squares and length, one stage per result bit of the magnitude search
// (shift-add, no multiplier), and the output register. Stalls ripple back only
// through occupied stages, so bubbles are squeezed out. Results do not depend on
// the coordinates' fraction bits.
module triangle_unit_normal_unit #(
  parameter int CoordBits  = tun_pkg::COORD_BITS,
  parameter int NormalBits = tun_pkg::NORMAL_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic signed [CoordBits-1:0] ax_i,
  input  logic signed [CoordBits-1:0] ay_i,
  input  logic signed [CoordBits-1:0] az_i,
  input  logic signed [CoordBits-1:0] bx_i,
  input  logic signed [CoordBits-1:0] by_coord_i,
  input  logic signed [CoordBits-1:0] bz_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  input  logic signed [CoordBits-1:0] cz_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [NormalBits-1:0] nx_o,
  output logic signed [NormalBits-1:0] ny_o,
  output logic signed [NormalBits-1:0] nz_o,
  output logic                        degenerate_o
);

  localparam int NF  = tun_pkg::FRONT_STAGES;
  localparam int NS  = tun_pkg::SQUARE_STAGES;
  localparam int P   = NF + NS + NormalBits + 1;
  localparam int F   = NormalBits - 1;
  localparam int MW  = 2 * CoordBits + 1;
  localparam int SQW = 2 * MW;
  localparam int LW  = SQW + 2;
  localparam int RW  = SQW + 2 * F;
  localparam int SW  = LW + F + 1;

  logic [P-1:0] valid_q;
  logic [P-1:0] adv;

  logic signed [CoordBits-1:0] a_w [3];
  logic signed [CoordBits-1:0] b_w [3];
  logic signed [CoordBits-1:0] c_w [3];
  logic [2:0]    front_sign;
  logic [MW-1:0] front_mag [3];
  logic [SQW-1:0] sq_w [3];

  logic [2:0]     sign_w  [NormalBits+1];
  logic           degen_w [NormalBits+1];
  logic [LW-1:0]  len_w   [NormalBits+1];
  logic [RW-1:0]  r_w     [NormalBits+1][3];
  logic [SW-1:0]  s_w     [NormalBits+1][3];
  logic [NormalBits-1:0] q_w [NormalBits+1][3];

  logic [NormalBits-1:0] sat_d [3];
  logic [NormalBits-1:0] res_d [3];
  logic [NormalBits-1:0] res_q [3];
  logic                  degen_q;

  // stage advance: a stage moves when empty or when its successor moves
  always_comb begin
    adv[P-1] = !valid_q[P-1] || out_ready_i;
    for (int k = P - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[P-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < P; k++) begin
        if (adv[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign a_w[0] = ax_i;
  assign a_w[1] = ay_i;
  assign a_w[2] = az_i;
  assign b_w[0] = bx_i;
  assign b_w[1] = by_coord_i;
  assign b_w[2] = bz_i;
  assign c_w[0] = cx_i;
  assign c_w[1] = cy_i;
  assign c_w[2] = cz_i;

  // edges, cross product, sign and magnitude
  tun_front #(
    .CoordBits(CoordBits)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (adv[NF-1:0]),
    .cmd_i (command_i),
    .a_i   (a_w),
    .b_i   (b_w),
    .c_i   (c_w),
    .sign_o(front_sign),
    .mag_o (front_mag)
  );

  // exact squares and squared length
  tun_square #(
    .MagBits(MW)
  ) u_square (
    .clk_i  (clk_i),
    .en_i   (adv[NF+NS-1:NF]),
    .sign_i (front_sign),
    .mag_i  (front_mag),
    .sign_o (sign_w[0]),
    .sq_o   (sq_w),
    .len_o  (len_w[0]),
    .degen_o(degen_w[0])
  );

  // search start: remainder n^2 * 2^(2F), no bits set yet
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r_w[0][c] = RW'(sq_w[c]) << (2 * F);
      s_w[0][c] = '0;
      q_w[0][c] = '0;
    end
  end

  // one result bit per stage, most significant first
  for (genvar i = 0; i < NormalBits; i++) begin : g_step
    tun_step #(
      .Bit    (NormalBits - 1 - i),
      .QBits  (NormalBits),
      .LenBits(LW),
      .RemBits(RW),
      .AccBits(SW)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (adv[NF+NS+i]),
      .sign_i (sign_w[i]),
      .degen_i(degen_w[i]),
      .len_i  (len_w[i]),
      .r_i    (r_w[i]),
      .s_i    (s_w[i]),
      .q_i    (q_w[i]),
      .sign_o (sign_w[i+1]),
      .degen_o(degen_w[i+1]),
      .len_o  (len_w[i+1]),
      .r_o    (r_w[i+1]),
      .s_o    (s_w[i+1]),
      .q_o    (q_w[i+1])
    );
  end

  // saturate plus one, apply sign, zero a degenerate item
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_d[c] = q_w[NormalBits][c][NormalBits-1] ? {1'b0, {(NormalBits-1){1'b1}}}
                                                  : q_w[NormalBits][c];
      if (degen_w[NormalBits]) begin
        res_d[c] = '0;
      end else if (sign_w[NormalBits][c]) begin
        res_d[c] = -sat_d[c];
      end else begin
        res_d[c] = sat_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[P-1]) begin
      res_q   <= res_d;
      degen_q <= degen_w[NormalBits];
    end
  end

  assign nx_o         = res_q[0];
  assign ny_o         = res_q[1];
  assign nz_o         = res_q[2];
  assign degenerate_o = degen_q;

  // an empty output stage never holds back the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // a degenerate item carries a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> nx_o == '0 && ny_o == '0 && nz_o == '0)
    else $error("degenerate item with nonzero normal");

  // saturation is symmetric, so the most negative code never appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nx_o != {1'b1, {(NormalBits-1){1'b0}}}
                 && ny_o != {1'b1, {(NormalBits-1){1'b0}}}
                 && nz_o != {1'b1, {(NormalBits-1){1'b0}}})
    else $error("unsaturated minus one on output");

endmodule

### hw/rtl/tun_front.sv
module tun_front #(
  parameter int CoordBits = tun_pkg::COORD_BITS
) (
  input  logic                         clk_i,
  input  logic [tun_pkg::FRONT_STAGES-1:0] en_i,
  input  logic                         cmd_i,
  input  logic signed [CoordBits-1:0]  a_i [3],
  input  logic signed [CoordBits-1:0]  b_i [3],
  input  logic signed [CoordBits-1:0]  c_i [3],
  output logic [2:0]                   sign_o,
  output logic [2*CoordBits:0]         mag_o [3]
);

  localparam int EW = CoordBits + 1;
  localparam int PW = 2 * EW;
  localparam int MW = 2 * CoordBits + 1;

  logic                        cmd0_q, cmd1_q;
  logic signed [CoordBits-1:0] a0_q [3];
  logic signed [CoordBits-1:0] a1_q [3];
  logic signed [EW-1:0]        e1_q [3];
  logic signed [EW-1:0]        e2_q [3];
  logic signed [PW-1:0]        p_q [3];
  logic signed [PW-1:0]        m_q [3];
  logic signed [PW:0]          n_d [3];
  logic [PW:0]                 abs_d [3];

  // edge vectors from the first vertex
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cmd0_q <= cmd_i;
      for (int c = 0; c < 3; c++) begin
        a0_q[c] <= a_i[c];
        e1_q[c] <= $signed({b_i[c][CoordBits-1], b_i[c]})
                 - $signed({a_i[c][CoordBits-1], a_i[c]});
        e2_q[c] <= $signed({c_i[c][CoordBits-1], c_i[c]})
                 - $signed({a_i[c][CoordBits-1], a_i[c]});
      end
    end
  end

  // cross product partial terms, one multiplier each
  for (genvar c = 0; c < 3; c++) begin : g_prod
    localparam int J = (c + 1) % 3;
    localparam int K = (c + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        p_q[c]  <= PW'(e1_q[J]) * PW'(e2_q[K]);
        m_q[c]  <= PW'(e1_q[K]) * PW'(e2_q[J]);
        a1_q[c] <= a0_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cmd1_q <= cmd0_q;
    end
  end

  // difference or plain vector, split into sign and magnitude
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (cmd1_q == tun_pkg::CMD_NORMALIZE) begin
        n_d[c] = (PW+1)'(a1_q[c]);
      end else begin
        n_d[c] = (PW+1)'(p_q[c]) - (PW+1)'(m_q[c]);
      end
      abs_d[c] = n_d[c][PW] ? (PW+1)'(-n_d[c]) : n_d[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int c = 0; c < 3; c++) begin
        sign_o[c] <= n_d[c][PW];
        mag_o[c]  <= abs_d[c][MW-1:0];
      end
    end
  end

endmodule

### hw/rtl/tun_square.sv
module tun_square #(
  parameter int MagBits = 2 * tun_pkg::COORD_BITS + 1
) (
  input  logic                              clk_i,
  input  logic [tun_pkg::SQUARE_STAGES-1:0] en_i,
  input  logic [2:0]                        sign_i,
  input  logic [MagBits-1:0]                mag_i [3],
  output logic [2:0]                        sign_o,
  output logic [2*MagBits-1:0]              sq_o [3],
  output logic [2*MagBits+1:0]              len_o,
  output logic                              degen_o
);

  localparam int HW  = (MagBits + 1) / 2;
  localparam int TW  = MagBits - HW;
  localparam int SQW = 2 * MagBits;
  localparam int LW  = SQW + 2;

  logic [2:0]       sign3_q, sign4_q;
  logic [2*TW-1:0]  hh_q [3];
  logic [MagBits-1:0] hl_q [3];
  logic [2*HW-1:0]  ll_q [3];
  logic [SQW-1:0]   sq4_q [3];

  // partial products of each square
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sign3_q <= sign_i;
      for (int c = 0; c < 3; c++) begin
        hh_q[c] <= (2*TW)'(mag_i[c][MagBits-1:HW]) * (2*TW)'(mag_i[c][MagBits-1:HW]);
        hl_q[c] <= MagBits'(mag_i[c][MagBits-1:HW]) * MagBits'(mag_i[c][HW-1:0]);
        ll_q[c] <= (2*HW)'(mag_i[c][HW-1:0]) * (2*HW)'(mag_i[c][HW-1:0]);
      end
    end
  end

  // recombine the squares
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sign4_q <= sign3_q;
      for (int c = 0; c < 3; c++) begin
        sq4_q[c] <= {hh_q[c], {(2*HW){1'b0}}} + (SQW'(hl_q[c]) << (HW + 1))
                  + SQW'(ll_q[c]);
      end
    end
  end

  // squared length
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sign_o  <= sign4_q;
      sq_o    <= sq4_q;
      len_o   <= LW'(sq4_q[0]) + LW'(sq4_q[1]) + LW'(sq4_q[2]);
      degen_o <= ~|{sq4_q[0], sq4_q[1], sq4_q[2]};
    end
  end

endmodule

### hw/rtl/tun_step.sv
module tun_step #(
  parameter int Bit     = 0,
  parameter int QBits   = tun_pkg::NORMAL_BITS,
  parameter int LenBits = 100,
  parameter int RemBits = 128,
  parameter int AccBits = 116
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2:0]         sign_i,
  input  logic               degen_i,
  input  logic [LenBits-1:0] len_i,
  input  logic [RemBits-1:0] r_i [3],
  input  logic [AccBits-1:0] s_i [3],
  input  logic [QBits-1:0]   q_i [3],
  output logic [2:0]         sign_o,
  output logic               degen_o,
  output logic [LenBits-1:0] len_o,
  output logic [RemBits-1:0] r_o [3],
  output logic [AccBits-1:0] s_o [3],
  output logic [QBits-1:0]   q_o [3]
);

  localparam int DW = LenBits + 2 * QBits;

  logic [DW-1:0]      dec_d [3];
  logic               fit_d [3];
  logic [RemBits-1:0] r_d [3];
  logic [AccBits-1:0] s_d [3];
  logic [QBits-1:0]   q_d [3];

  // try this result bit: ((q + 2^b)^2 - q^2) * len against the remainder
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dec_d[c] = (DW'(s_i[c]) << (Bit + 1)) + (DW'(len_i) << (2 * Bit));
      fit_d[c] = dec_d[c] <= DW'(r_i[c]);
      r_d[c]   = fit_d[c] ? r_i[c] - dec_d[c][RemBits-1:0] : r_i[c];
      s_d[c]   = fit_d[c] ? s_i[c] + (AccBits'(len_i) << Bit) : s_i[c];
      q_d[c]   = fit_d[c] ? q_i[c] | (QBits'(1) << Bit) : q_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_o  <= sign_i;
      degen_o <= degen_i;
      len_o   <= len_i;
      r_o     <= r_d;
      s_o     <= s_d;
      q_o     <= q_d;
    end
  end

endmodule
